### hw/rtl/tlni_pkg.sv
`default_nettype none
package tlni_pkg;

  localparam int MAX_SIDE  = 64;
  localparam int COORD_W   = $clog2(MAX_SIDE);
  localparam int EXT_W     = 7;
  localparam int DIM_W     = 3;
  localparam int IDX_W     = 24;
  localparam int NSLOT     = 8;
  localparam int NAXIS     = 4;
  localparam int REG_IDX_W = 3;
  localparam int REG_W     = 7;

  localparam logic [REG_IDX_W-1:0] REG_EXTENT_X  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_EXTENT_Y  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_EXTENT_Z  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_EXTENT_W  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIMENSION = 3'd4;

  localparam logic [DIM_W-1:0] DIM_2 = 3'd2;
  localparam logic [DIM_W-1:0] DIM_3 = 3'd3;
  localparam logic [DIM_W-1:0] DIM_4 = 3'd4;

  localparam logic [EXT_W-1:0] EXT_RESET_XY = 7'd16;
  localparam logic [EXT_W-1:0] EXT_RESET_ZW = 7'd1;
  localparam logic [EXT_W-1:0] EXT_ONE      = 7'd1;
  localparam logic [EXT_W-1:0] EXT_MAX      = EXT_W'(MAX_SIDE);

  typedef struct packed {
    logic [EXT_W-1:0] extent_x;
    logic [EXT_W-1:0] extent_y;
    logic [EXT_W-1:0] extent_z;
    logic [EXT_W-1:0] extent_w;
    logic [DIM_W-1:0] dimension;
  } cfg_t;

  // coord_x in the lowest bits
  typedef struct packed {
    logic [COORD_W-1:0] coord_w;
    logic [COORD_W-1:0] coord_z;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_x;
  } in_t;

  // point_index in the lowest bits, then slot 0 .. slot 7
  typedef struct packed {
    logic [NSLOT-1:0][IDX_W-1:0] nbr_slot;
    logic [IDX_W-1:0]            point_index;
  } out_t;

  function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] e);
    logic [EXT_W-1:0] r;
    r = e;
    if (e == '0) begin
      r = EXT_ONE;
    end else if (e > EXT_MAX) begin
      r = EXT_MAX;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/tlni_core.sv
`default_nettype none
module tlni_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tlni_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tlni_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tlni_pkg::out_t      out_data,
  output logic                out_err
);
  import tlni_pkg::*;

  localparam int PW   = 13;  // x*ey+y, ez*ew, z*ew+w
  localparam int SX_W = 19;  // ey*ez*ew

  typedef struct packed {
    logic [NAXIS-1:0][COORD_W-1:0] c;
    logic [NAXIS-1:0][EXT_W-1:0]   e;
    logic [NAXIS-1:0]              hi;  // coordinate at top edge
    logic [NAXIS-1:0]              lo;  // coordinate at zero
    logic [DIM_W-1:0]              dim;
    logic                          err;
  } s1_t;

  typedef struct packed {
    logic [PW-1:0]               szw;
    logic [PW-1:0]               txy;
    logic [PW-1:0]               zw;
    logic [NAXIS-1:0][EXT_W-1:0] e;
    logic [NAXIS-1:0]            hi;
    logic [NAXIS-1:0]            lo;
    logic [DIM_W-1:0]            dim;
    logic                        err;
  } s2_t;

  typedef struct packed {
    logic [SX_W-1:0]             sx;
    logic [IDX_W-1:0]            idxa;
    logic [PW-1:0]               szw;
    logic [PW-1:0]               zw;
    logic [NAXIS-1:0][EXT_W-1:0] e;
    logic [NAXIS-1:0]            hi;
    logic [NAXIS-1:0]            lo;
    logic [DIM_W-1:0]            dim;
    logic                        err;
  } s3_t;

  typedef struct packed {
    logic [IDX_W-1:0]            idx;
    logic [NAXIS-1:0][IDX_W-1:0] stride;
    logic [NAXIS-1:0][IDX_W-1:0] off;
    logic [NAXIS-1:0]            hi;
    logic [NAXIS-1:0]            lo;
    logic [DIM_W-1:0]            dim;
    logic                        err;
  } s4_t;

  typedef struct packed {
    out_t             res;
    logic [DIM_W-1:0] dim;
    logic             err;
  } s5_t;

  logic [5:1] v;
  logic [5:1] en;
  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  s5_t s5, s5_next;

  logic                          dim_ok;
  logic [NAXIS-1:0][IDX_W-1:0]   nb_plus;
  logic [NAXIS-1:0][IDX_W-1:0]   nb_minus;

  // per-stage enable: a stage loads when empty or when the next one moves
  always_comb begin
    en[5] = !v[5] || out_ready;
    for (int i = 4; i >= 1; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end
  assign in_ready = en[1];

  // stage 1: clamp extents, fold unused axes to extent 1 / coordinate 0, range check
  always_comb begin
    s1_next.dim = cfg.dimension;
    dim_ok = (cfg.dimension == DIM_2) || (cfg.dimension == DIM_3) ||
             (cfg.dimension == DIM_4);
    s1_next.e[0] = clamp_extent(cfg.extent_x);
    s1_next.e[1] = clamp_extent(cfg.extent_y);
    s1_next.e[2] = (cfg.dimension == DIM_3 || cfg.dimension == DIM_4) ?
                   clamp_extent(cfg.extent_z) : EXT_ONE;
    s1_next.e[3] = (cfg.dimension == DIM_4) ? clamp_extent(cfg.extent_w) : EXT_ONE;
    s1_next.c[0] = in_data.coord_x;
    s1_next.c[1] = in_data.coord_y;
    s1_next.c[2] = (cfg.dimension == DIM_3 || cfg.dimension == DIM_4) ?
                   in_data.coord_z : '0;
    s1_next.c[3] = (cfg.dimension == DIM_4) ? in_data.coord_w : '0;
    s1_next.err = !dim_ok;
    for (int a = 0; a < NAXIS; a++) begin
      if (EXT_W'(s1_next.c[a]) >= s1_next.e[a]) begin
        s1_next.err = 1'b1;
      end
      s1_next.hi[a] = (EXT_W'(s1_next.c[a]) == s1_next.e[a] - EXT_ONE);
      s1_next.lo[a] = (s1_next.c[a] == '0);
    end
  end

  // stage 2: partial products
  always_comb begin
    s2_next.szw = PW'(s1.e[2]) * PW'(s1.e[3]);
    s2_next.txy = PW'(s1.c[0]) * PW'(s1.e[1]) + PW'(s1.c[1]);
    s2_next.zw  = PW'(s1.c[2]) * PW'(s1.e[3]) + PW'(s1.c[3]);
    s2_next.e   = s1.e;
    s2_next.hi  = s1.hi;
    s2_next.lo  = s1.lo;
    s2_next.dim = s1.dim;
    s2_next.err = s1.err;
  end

  // stage 3: x stride and upper part of the point index
  always_comb begin
    s3_next.sx   = SX_W'(s2.e[1]) * SX_W'(s2.szw);
    s3_next.idxa = IDX_W'(s2.txy) * IDX_W'(s2.szw);
    s3_next.szw  = s2.szw;
    s3_next.zw   = s2.zw;
    s3_next.e    = s2.e;
    s3_next.hi   = s2.hi;
    s3_next.lo   = s2.lo;
    s3_next.dim  = s2.dim;
    s3_next.err  = s2.err;
  end

  // stage 4: point index, strides and wrap offsets (extent-1)*stride
  always_comb begin
    s4_next.idx       = s3.idxa + IDX_W'(s3.zw);
    s4_next.stride[0] = IDX_W'(s3.sx);
    s4_next.stride[1] = IDX_W'(s3.szw);
    s4_next.stride[2] = IDX_W'(s3.e[3]);
    s4_next.stride[3] = IDX_W'(1);
    s4_next.off[0]    = IDX_W'(s3.e[0] - EXT_ONE) * IDX_W'(s3.sx);
    s4_next.off[1]    = IDX_W'(s3.e[1] - EXT_ONE) * IDX_W'(s3.szw);
    s4_next.off[2]    = IDX_W'(s3.e[2] - EXT_ONE) * IDX_W'(s3.e[3]);
    s4_next.off[3]    = IDX_W'(s3.e[3] - EXT_ONE);
    s4_next.hi        = s3.hi;
    s4_next.lo        = s3.lo;
    s4_next.dim       = s3.dim;
    s4_next.err       = s3.err;
  end

  // stage 5: neighbors by step or wrap, then slot order by dimension
  always_comb begin
    for (int a = 0; a < NAXIS; a++) begin
      nb_plus[a]  = s4.hi[a] ? s4.idx - s4.off[a] : s4.idx + s4.stride[a];
      nb_minus[a] = s4.lo[a] ? s4.idx + s4.off[a] : s4.idx - s4.stride[a];
    end
    s5_next.res = '0;
    s5_next.dim = s4.dim;
    s5_next.err = s4.err;
    if (!s4.err) begin
      s5_next.res.point_index = s4.idx;
      unique case (s4.dim)
        DIM_2: begin
          s5_next.res.nbr_slot[0] = nb_plus[0];
          s5_next.res.nbr_slot[1] = nb_plus[1];
          s5_next.res.nbr_slot[2] = nb_minus[0];
          s5_next.res.nbr_slot[3] = nb_minus[1];
        end
        DIM_3: begin
          s5_next.res.nbr_slot[0] = nb_plus[0];
          s5_next.res.nbr_slot[1] = nb_plus[1];
          s5_next.res.nbr_slot[2] = nb_plus[2];
          s5_next.res.nbr_slot[3] = nb_minus[0];
          s5_next.res.nbr_slot[4] = nb_minus[1];
          s5_next.res.nbr_slot[5] = nb_minus[2];
        end
        DIM_4: begin
          for (int a = 0; a < NAXIS; a++) begin
            s5_next.res.nbr_slot[a]         = nb_plus[a];
            s5_next.res.nbr_slot[a + NAXIS] = nb_minus[a];
          end
        end
        default: begin
          s5_next.res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int i = 2; i <= 5; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1 <= s1_next;
    end
    if (en[2]) begin
      s2 <= s2_next;
    end
    if (en[3]) begin
      s3 <= s3_next;
    end
    if (en[4]) begin
      s4 <= s4_next;
    end
    if (en[5]) begin
      s5 <= s5_next;
    end
  end

  assign out_valid = v[5];
  assign out_data  = s5.res;
  assign out_err   = s5.err;

`ifndef SYNTHESIS
  // input only backs up when every stage holds a beat and the sink stalls
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v && !out_ready))
    else $error("input stalled with a bubble in the pipeline");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_err) |-> (out_data == '0))
    else $error("error beat carries nonzero indices");

  a_2d_unused: assert property (@(posedge clk) disable iff (rst)
    (out_valid && s5.dim == DIM_2) |->
      (out_data.nbr_slot[4] == '0 && out_data.nbr_slot[5] == '0 &&
       out_data.nbr_slot[6] == '0 && out_data.nbr_slot[7] == '0))
    else $error("unused 2D slots not zero");

  a_3d_unused: assert property (@(posedge clk) disable iff (rst)
    (out_valid && s5.dim == DIM_3) |->
      (out_data.nbr_slot[6] == '0 && out_data.nbr_slot[7] == '0))
    else $error("unused 3D slots not zero");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (v == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

### hw/rtl/torus_lattice_neighbour_ids_top.sv
`default_nettype none
// Throughput: one beat per cycle unless m_axis_tready stalls the output; five register
// stages (clamp and range check, multiplier chain for strides, index and wrap
// offsets, then the neighbor adders).
// Reset (rst, synchronous): pipeline emptied, extent_x/extent_y = 16,
// extent_z/extent_w = 1, dimension = 2.
module torus_lattice_neighbour_ids_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [4*tlni_pkg::COORD_W-1:0]     s_axis_tdata,  // coord_x, coord_y, coord_z, coord_w
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [(tlni_pkg::NSLOT+1)*tlni_pkg::IDX_W-1:0] m_axis_tdata,
                                                  // point_index, nbr_slot0 .. nbr_slot7
  output logic                                    m_axis_tuser,  // coord_error
  input  wire logic                               cfg_we,
  input  wire logic [tlni_pkg::REG_IDX_W-1:0]     cfg_index,
  input  wire logic [tlni_pkg::REG_W-1:0]         cfg_data
);
  import tlni_pkg::*;

  cfg_t cfg;
  in_t  in_data;
  out_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.extent_x  <= EXT_RESET_XY;
      cfg.extent_y  <= EXT_RESET_XY;
      cfg.extent_z  <= EXT_RESET_ZW;
      cfg.extent_w  <= EXT_RESET_ZW;
      cfg.dimension <= DIM_2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXTENT_X:  cfg.extent_x  <= cfg_data;
        REG_EXTENT_Y:  cfg.extent_y  <= cfg_data;
        REG_EXTENT_Z:  cfg.extent_z  <= cfg_data;
        REG_EXTENT_W:  cfg.extent_w  <= cfg_data;
        REG_DIMENSION: cfg.dimension <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_data      = s_axis_tdata;
  assign m_axis_tdata = out_data;

  tlni_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (in_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data),
    .out_err   (m_axis_tuser)
  );

endmodule
`default_nettype wire
